FILE: design/glas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glas_pkg: shared types and constants
// Operation codes, sequencer states, fixed-point constants, CORDIC angle table.
// ----------------------------------------------------------------------------
package glas_pkg;

    localparam int MAX_SEGMENTS = 63;
    localparam int SEG_W        = 6;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int CW           = 60;
    localparam int MUL_AW       = 34;
    localparam int MUL_BW       = 32;
    localparam int MUL_PW       = MUL_AW + MUL_BW;
    localparam int MUL_CNT_W    = 5;
    localparam int DIV_NW       = 40;
    localparam int DIV_DW       = 31;
    localparam int DIV_CNT_W    = 6;
    localparam int SQ_IW        = 64;
    localparam int SQ_RW        = 32;

    localparam logic [30:0] SEG_LEN_RESET   = 31'd327680;
    localparam logic [31:0] TWO_PI_Q28      = 32'd1686629713;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] HALF_TURN       = 32'h8000_0000;
    localparam logic [31:0] EIGHTH_TURN     = 32'h2000_0000;

    typedef enum logic [1:0] {
        OP_LINE    = 2'd0,
        OP_ARC_NEG = 2'd1,
        OP_ARC_POS = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_I,
        ST_SQ_J,
        ST_SQRT,
        ST_GAIN,
        ST_VEC1,
        ST_VEC2,
        ST_SWEEP,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_LEN,
        ST_DIVC,
        ST_PT_MUL,
        ST_PT_DIV,
        ST_PT_ROT,
        ST_PT_EMIT,
        ST_TGT,
        ST_FLUSH
    } t_state;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/gcode_arc_line_segmenter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcode_arc_line_segmenter: line and arc move segmenter
// Turns line and G02/G03 arc moves into a stream of Q16.16 path points.
// ----------------------------------------------------------------------------
// One move is taken at a time. An arc move runs a setup and then works out one
// point per segment, n being the segment count (0..63): setup runs two
// squares, the radius root, the gain product, two vectoring CORDIC passes,
// three length products and the count division; each point then runs one
// serial product, one serial division and one 24-step CORDIC rotation. The
// output register and a one-point hold stage let a finished point wait while
// the next one is worked out; the last point of a move is flagged with tlast.
module gcode_arc_line_segmenter import glas_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // target_x, target_y, offset_i, offset_j
    input  wire logic [127:0] s_axis_tdata,
    // operation
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // point_x, point_y
    output logic [63:0]       m_axis_tdata,
    output logic              m_axis_tlast,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [30:0]  i_cfg_data
);
    t_state r_state, n_state;
    logic   r_go;
    logic [30:0] r_seglen;
    logic [31:0] r_last_x, r_last_y, n_last_x, n_last_y;
    logic        r_pend_v, n_pend_v;
    logic        r_out_v, n_out_v;
    logic        w_load_out, w_out_last, w_take;

    t_op         r_op;
    logic [31:0] r_tx, r_ty, r_oi, r_oj;
    logic [33:0] r_cx, r_cy;
    logic [63:0] r_sq;
    logic [31:0] r_r;
    logic [53:0] r_x0;
    logic [32:0] r_a1;
    logic [31:0] r_a2;
    logic        r_sw_neg;
    logic [32:0] r_as;
    logic [49:0] r_p1;
    logic [33:0] r_m;
    logic [37:0] r_len;
    logic [SEG_W-1:0] r_segs, r_k;
    logic [39:0] r_prod;
    logic [31:0] r_ang;
    logic [31:0] r_pend_x, r_pend_y;
    logic [31:0] r_out_x, r_out_y;
    logic        r_out_last;

    logic              mul_start, mul_done;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_PW-1:0] mul_p;
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_q;
    logic [DIV_DW-1:0] div_den;
    logic              sq_start, sq_done;
    logic [SQ_RW-1:0]  sq_root;
    logic              cor_start, cor_done, cor_vec;
    logic signed [CW-1:0] cor_ix, cor_iy, cor_ox, cor_oy;
    logic [31:0]       cor_iz, cor_oz;

    logic              w_acc;
    logic              w_out_free;
    logic [31:0]       w_abs_oi, w_abs_oj;
    logic signed [34:0] w_vx, w_vy, w_vxa, w_vya;
    logic              w_vneg, w_vzero;
    logic [31:0]       w_vang;
    logic signed [33:0] w_sw0, w_sw;
    logic [33:0]       w_a1e, w_a2e;
    logic [SEG_W-1:0]  w_cnt;
    logic [31:0]       w_qt, w_rt;
    logic [1:0]        w_quad;
    logic [31:0]       w_res;
    logic signed [CW-1:0] w_rx, w_ry, w_rxr, w_ryr;
    logic signed [39:0] w_px, w_py;
    logic [31:0]       w_cx, w_cy;
    logic              w_same;
    logic [50:0]       w_msum;

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] s;
        if (v > 40'sd2147483647) begin
            s = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            s = 32'h8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    glas_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_prod(mul_p)
    );

    glas_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_q)
    );

    glas_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_rad(r_sq), .o_done(sq_done), .o_root(sq_root)
    );

    glas_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start), .i_vec(cor_vec),
        .i_x(cor_ix), .i_y(cor_iy), .i_z(cor_iz),
        .o_done(cor_done), .o_x(cor_ox), .o_y(cor_oy), .o_z(cor_oz)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_v || m_axis_tready;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign m_axis_tlast  = r_out_last;

    // operand selection for the shared units
    always_comb begin
        w_abs_oi = r_oi[31] ? (~r_oi + 32'd1) : r_oi;
        w_abs_oj = r_oj[31] ? (~r_oj + 32'd1) : r_oj;
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_SQ_I: begin
                mul_a = {2'b00, w_abs_oi};
                mul_b = w_abs_oi;
            end
            ST_SQ_J: begin
                mul_a = {2'b00, w_abs_oj};
                mul_b = w_abs_oj;
            end
            ST_GAIN: begin
                mul_a = {2'b00, r_r};
                mul_b = CORDIC_GAIN_Q30;
            end
            ST_LEN_HI: begin
                mul_a = {17'd0, r_as[32:16]};
                mul_b = r_r;
            end
            ST_LEN_LO: begin
                mul_a = {18'd0, r_as[15:0]};
                mul_b = r_r;
            end
            ST_LEN: begin
                mul_a = r_m;
                mul_b = TWO_PI_Q28;
            end
            ST_PT_MUL: begin
                mul_a = {1'b0, r_as};
                mul_b = {{(MUL_BW-SEG_W){1'b0}}, r_k};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_start = r_go && (r_state == ST_SQ_I || r_state == ST_SQ_J ||
                    r_state == ST_GAIN || r_state == ST_LEN_HI ||
                    r_state == ST_LEN_LO || r_state == ST_LEN || r_state == ST_PT_MUL);

        div_start = r_go && (r_state == ST_DIVC || r_state == ST_PT_DIV);
        if (r_state == ST_DIVC) begin
            div_num = {2'b00, r_len};
            div_den = r_seglen;
        end else begin
            div_num = r_prod;
            div_den = {{(DIV_DW-SEG_W){1'b0}}, r_segs};
        end
        w_cnt = (r_seglen == '0 || div_q > DIV_NW'(MAX_SEGMENTS)) ?
                SEG_W'(MAX_SEGMENTS) : div_q[SEG_W-1:0];

        sq_start = r_go && (r_state == ST_SQRT);

        // vector for the angle passes
        if (r_state == ST_VEC1) begin
            w_vx = -{{3{r_oi[31]}}, r_oi};
            w_vy = -{{3{r_oj[31]}}, r_oj};
        end else begin
            w_vx = {{3{r_tx[31]}}, r_tx} - {r_cx[33], r_cx};
            w_vy = {{3{r_ty[31]}}, r_ty} - {r_cy[33], r_cy};
        end
        w_vneg  = w_vx[34];
        w_vzero = (w_vx == '0) && (w_vy == '0);
        w_vxa   = w_vneg ? -w_vx : w_vx;
        w_vya   = w_vneg ? -w_vy : w_vy;
        w_vang  = w_vzero ? 32'd0 : ((w_vneg ? HALF_TURN : 32'd0) + cor_oz);

        // rotation angle split into quadrant and residue
        w_qt   = r_ang + EIGHTH_TURN;
        w_quad = w_qt[31:30];
        w_res  = r_ang - {w_quad, 30'd0};

        cor_vec   = (r_state == ST_VEC1 || r_state == ST_VEC2);
        cor_start = r_go && (cor_vec || r_state == ST_PT_ROT);
        if (cor_vec) begin
            cor_ix = {{5{w_vxa[34]}}, w_vxa, 20'd0};
            cor_iy = {{5{w_vya[34]}}, w_vya, 20'd0};
            cor_iz = '0;
        end else begin
            cor_ix = {6'd0, r_x0};
            cor_iy = '0;
            cor_iz = w_res;
        end

        unique case (w_quad)
            2'd1: begin
                w_rx = -cor_oy;
                w_ry = cor_ox;
            end
            2'd2: begin
                w_rx = -cor_ox;
                w_ry = -cor_oy;
            end
            2'd3: begin
                w_rx = cor_oy;
                w_ry = -cor_ox;
            end
            default: begin
                w_rx = cor_ox;
                w_ry = cor_oy;
            end
        endcase
        w_rxr = w_rx + CW'(64'sd2097152);
        w_ryr = w_ry + CW'(64'sd2097152);
        w_px  = {{6{r_cx[33]}}, r_cx} + {{2{w_rxr[CW-1]}}, w_rxr[CW-1:22]};
        w_py  = {{6{r_cy[33]}}, r_cy} + {{2{w_ryr[CW-1]}}, w_ryr[CW-1:22]};

        // sweep with direction adjust
        w_sw0 = $signed({2'b00, r_a2}) - $signed({2'b00, r_a1[31:0]});
        w_a1e = {1'b0, r_a1};
        w_a2e = {2'b00, r_a2};
        if (w_sw0[33] && r_op == OP_ARC_POS) begin
            w_a2e = w_a2e + 34'h1_0000_0000;
        end else if (!w_sw0[33] && w_sw0 != '0 && r_op == OP_ARC_NEG) begin
            w_a1e = w_a1e + 34'h1_0000_0000;
        end
        w_sw = $signed(w_a2e) - $signed(w_a1e);

        w_msum = {1'b0, r_p1} + {19'd0, mul_p[47:16]};
    end

    // sequencer next state and emission of candidate points through the hold stage
    always_comb begin
        if (r_state == ST_TGT) begin
            w_cx = r_tx;
            w_cy = r_ty;
        end else begin
            w_cx = sat32(w_px);
            w_cy = sat32(w_py);
        end
        w_same     = (w_cx == r_last_x) && (w_cy == r_last_y);
        w_take     = w_same || !r_pend_v || w_out_free;
        w_load_out = 1'b0;
        w_out_last = 1'b0;
        n_pend_v   = r_pend_v;
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_state    = r_state;

        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (t_op'(s_axis_tuser))
                        OP_LINE:    n_state = ST_TGT;
                        OP_ARC_NEG: n_state = ST_SQ_I;
                        OP_ARC_POS: n_state = ST_SQ_I;
                        OP_NONE:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SQ_I:   if (mul_done) n_state = ST_SQ_J;
            ST_SQ_J:   if (mul_done) n_state = ST_SQRT;
            ST_SQRT:   if (sq_done) n_state = ST_GAIN;
            ST_GAIN:   if (mul_done) n_state = ST_VEC1;
            ST_VEC1:   if (cor_done) n_state = ST_VEC2;
            ST_VEC2:   if (cor_done) n_state = ST_SWEEP;
            ST_SWEEP:  n_state = ST_LEN_HI;
            ST_LEN_HI: if (mul_done) n_state = ST_LEN_LO;
            ST_LEN_LO: if (mul_done) n_state = ST_LEN;
            ST_LEN:    if (mul_done) n_state = ST_DIVC;
            ST_DIVC: begin
                if (div_done) begin
                    n_state = (w_cnt == '0) ? ST_TGT : ST_PT_MUL;
                end
            end
            ST_PT_MUL: if (mul_done) n_state = ST_PT_DIV;
            ST_PT_DIV: if (div_done) n_state = ST_PT_ROT;
            ST_PT_ROT: if (cor_done) n_state = ST_PT_EMIT;
            ST_PT_EMIT, ST_TGT: begin
                if (w_take) begin
                    if (!w_same) begin
                        w_load_out = r_pend_v;
                        n_pend_v   = 1'b1;
                        n_last_x   = w_cx;
                        n_last_y   = w_cy;
                    end
                    if (r_state == ST_TGT) begin
                        n_state = ST_FLUSH;
                    end else if (r_k == r_segs - 1'b1) begin
                        n_state = ST_TGT;
                    end else begin
                        n_state = ST_PT_MUL;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    w_load_out = 1'b1;
                    w_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_v = (r_out_v && !m_axis_tready) || w_load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_go     <= 1'b0;
            r_seglen <= SEG_LEN_RESET;
            r_last_x <= '0;
            r_last_y <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_go     <= (n_state != r_state);
            r_last_x <= n_last_x;
            r_last_y <= n_last_y;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg_valid) begin
                r_seglen <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op <= t_op'(s_axis_tuser);
            r_tx <= s_axis_tdata[31:0];
            r_ty <= s_axis_tdata[63:32];
            r_oi <= s_axis_tdata[95:64];
            r_oj <= s_axis_tdata[127:96];
            r_cx <= {{2{r_last_x[31]}}, r_last_x}
                    + {{2{s_axis_tdata[95]}}, s_axis_tdata[95:64]};
            r_cy <= {{2{r_last_y[31]}}, r_last_y}
                    + {{2{s_axis_tdata[127]}}, s_axis_tdata[127:96]};
        end
        if (r_state == ST_SQ_I && mul_done) begin
            r_sq <= mul_p[63:0];
        end
        if (r_state == ST_SQ_J && mul_done) begin
            r_sq <= r_sq + mul_p[63:0];
        end
        if (r_state == ST_SQRT && sq_done) begin
            r_r <= sq_root;
        end
        if (r_state == ST_GAIN && mul_done) begin
            r_x0 <= mul_p[61:8];
        end
        if (r_state == ST_VEC1 && cor_done) begin
            r_a1 <= {1'b0, w_vang};
        end
        if (r_state == ST_VEC2 && cor_done) begin
            r_a2 <= w_vang;
        end
        if (r_state == ST_SWEEP) begin
            r_a1     <= w_a1e[32:0];
            r_sw_neg <= w_sw[33];
            r_as     <= w_sw[33] ? 33'(-w_sw) : w_sw[32:0];
        end
        if (r_state == ST_LEN_HI && mul_done) begin
            r_p1 <= mul_p[49:0];
        end
        if (r_state == ST_LEN_LO && mul_done) begin
            r_m <= w_msum[49:16];
        end
        if (r_state == ST_LEN && mul_done) begin
            r_len <= mul_p[65:28];
        end
        if (r_state == ST_DIVC && div_done) begin
            r_segs <= w_cnt;
            r_k    <= '0;
        end
        if (r_state == ST_PT_MUL && mul_done) begin
            r_prod <= mul_p[39:0];
        end
        if (r_state == ST_PT_DIV && div_done) begin
            r_ang <= r_a1[31:0] + (r_sw_neg ? (~div_q[31:0] + 32'd1) : div_q[31:0]);
        end
        if (r_state == ST_PT_EMIT && w_take) begin
            r_k <= r_k + 1'b1;
        end
        if ((r_state == ST_PT_EMIT || r_state == ST_TGT) && w_take && !w_same) begin
            r_pend_x <= w_cx;
            r_pend_y <= w_cy;
        end
        if (w_load_out) begin
            r_out_x    <= r_pend_x;
            r_out_y    <= r_pend_y;
            r_out_last <= w_out_last;
        end
    end
endmodule
`default_nettype wire

FILE: design/glas_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glas_mul: serial multiplier
// Unsigned shift-add multiply, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module glas_mul import glas_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MUL_AW-1:0] i_a,
    input  wire logic [MUL_BW-1:0] i_b,
    output logic                   o_done,
    output logic [MUL_PW-1:0]      o_prod
);
    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_AW-1:0]    r_a;
    logic [MUL_PW-1:0]    r_p;
    logic [MUL_PW-1:0]    n_p;
    logic [MUL_AW:0]      w_sum;

    always_comb begin
        w_sum = {1'b0, r_p[MUL_PW-1:MUL_BW]} + (r_p[0] ? {1'b0, r_a} : '0);
        n_p   = {w_sum, r_p[MUL_BW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{MUL_AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule
`default_nettype wire

FILE: design/glas_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glas_div: serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module glas_div import glas_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_NW-1:0] i_num,
    input  wire logic [DIV_DW-1:0] i_den,
    output logic                   o_done,
    output logic [DIV_NW-1:0]      o_quot
);
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NW-1:0]    r_q;
    logic [DIV_DW-1:0]    r_rem;
    logic [DIV_DW-1:0]    r_den;
    logic [DIV_DW:0]      w_t;
    logic                 w_ge;
    logic [DIV_DW:0]      w_diff;

    always_comb begin
        w_t    = {r_rem, r_q[DIV_NW-1]};
        w_ge   = w_t >= {1'b0, r_den};
        w_diff = w_t - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_t[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

FILE: design/glas_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glas_sqrt: serial square root
// Floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module glas_sqrt import glas_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SQ_IW-1:0] i_rad,
    output logic                  o_done,
    output logic [SQ_RW-1:0]      o_root
);
    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [SQ_IW-1:0]     r_s;
    logic [SQ_RW+2:0]     r_rem;
    logic [SQ_RW-1:0]     r_root;
    logic [SQ_RW+2:0]     w_t;
    logic [SQ_RW+2:0]     w_trial;
    logic                 w_ge;

    always_comb begin
        w_t     = {r_rem[SQ_RW:0], r_s[SQ_IW-1:SQ_IW-2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = w_t >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(SQ_RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_s    <= {r_s[SQ_IW-3:0], 2'b00};
            r_rem  <= w_ge ? (w_t - w_trial) : w_t;
            r_root <= {r_root[SQ_RW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

FILE: design/glas_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glas_cordic: iterative CORDIC
// Vectoring or rotation, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module glas_cordic import glas_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_vec,
    input  wire logic signed [CW-1:0] i_x,
    input  wire logic signed [CW-1:0] i_y,
    input  wire logic [31:0]          i_z,
    output logic                      o_done,
    output logic signed [CW-1:0]      o_x,
    output logic signed [CW-1:0]      o_y,
    output logic [31:0]               o_z
);
    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_k;
    logic              r_vec;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic [31:0]       r_z;
    logic signed [CW-1:0] w_sx;
    logic signed [CW-1:0] w_sy;
    logic [31:0]       w_at;
    logic              w_plus;

    always_comb begin
        w_sx   = r_x >>> r_k;
        w_sy   = r_y >>> r_k;
        w_at   = atan_turn(r_k);
        w_plus = r_vec ? r_y[CW-1] : !r_z[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
                if (r_k == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_vec <= i_vec;
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
        end else if (r_busy) begin
            if (w_plus) begin
                r_x <= r_x - w_sy;
                r_y <= r_y + w_sx;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_sy;
                r_y <= r_y - w_sx;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule
`default_nettype wire

FILE: design/glas_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glas_checker: port checks
// Watches the segmenter ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module glas_checker import glas_pkg::*; (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [1:0]   s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [63:0]  m_axis_tdata,
    input wire logic         m_axis_tlast
);
    a_busy_after_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_NONE) |=> !s_axis_tready)
        else $error("input ready after a move was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output item changed");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output item valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");
endmodule

bind gcode_arc_line_segmenter glas_checker u_glas_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
